// ===== design/qcon_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcon_pkg
// Shared constants, types and fixed-point helpers of the Q-polynomial sag unit.
// ----------------------------------------------------------------------------
package qcon_pkg;

    localparam int NUM_TERMS = 7;
    localparam int N_COEF    = NUM_TERMS + 2;
    localparam int N_STEP    = NUM_TERMS + 1;
    localparam int N_CHAIN   = 3;
    localparam int DIV_LAT   = 64;
    localparam int PIPE_LAT  = 3 + DIV_LAT + 3 * N_STEP + 6;
    localparam int REG_W     = 32;
    localparam int IDX_W     = 3;
    localparam int OUT_W     = 48;

    typedef logic signed [63:0] t_q;

    localparam t_q MAXV    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_q OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam t_q OUT_MIN = 64'shFFFF_8000_0000_0000;

    localparam int Q_ROM [7][7] = '{
        '{     1,      0,      0,      0,      0,      0,    0},
        '{    -5,      6,      0,      0,      0,      0,    0},
        '{    15,    -42,     28,      0,      0,      0,    0},
        '{   -35,    168,   -252,    120,      0,      0,    0},
        '{    70,   -504,   1260,  -1320,    495,      0,    0},
        '{  -126,   1260,  -4620,   7920,  -6435,   2002,    0},
        '{   210,  -2772,  13860, -34320,  45045, -30030, 8008}
    };

    typedef enum logic [IDX_W-1:0] {
        REG_NORM_RADIUS,
        REG_COEF_0,
        REG_COEF_1,
        REG_COEF_2,
        REG_COEF_3,
        REG_COEF_4,
        REG_COEF_5,
        REG_COEF_6
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_tag;

    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
        logic        neg;
    } t_pp;

    typedef struct packed {
        logic valid;
        logic zero;
        t_q   v;
        t_q   vx;
        t_q   vy;
        t_q   vxx;
    } t_side;

    // partial products of the magnitudes, 32x32 each
    function automatic t_pp mulq_pp(input t_q a, input t_q b);
        logic [63:0] ua;
        logic [63:0] ub;
        t_pp         r;
        ua    = a[63] ? 64'(-a) : 64'(a);
        ub    = b[63] ? 64'(-b) : 64'(b);
        r.p00 = {32'd0, ua[31:0]}  * {32'd0, ub[31:0]};
        r.p01 = {32'd0, ua[31:0]}  * {32'd0, ub[63:32]};
        r.p10 = {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
        r.p11 = {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
        r.neg = a[63] ^ b[63];
        return r;
    endfunction

    // q.32 product, round half away from zero, saturate
    function automatic t_q mulq_fin(input t_pp p);
        logic [63:0] mid;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] hi2;
        logic [64:0] lo2;
        logic        sat;
        t_q          r;
        mid = {32'd0, p.p00[63:32]} + {32'd0, p.p01[31:0]} + {32'd0, p.p10[31:0]};
        lo  = {mid[31:0], p.p00[31:0]};
        hi  = p.p11 + {32'd0, p.p01[63:32]} + {32'd0, p.p10[63:32]}
            + {32'd0, mid[63:32]};
        lo2 = {1'b0, lo} + 65'h0_8000_0000;
        hi2 = hi + {63'd0, lo2[64]};
        sat = (hi2[63:32] != 32'd0) || hi2[31];
        r   = sat ? MAXV : t_q'({hi2[31:0], lo2[63:32]});
        return p.neg ? -r : r;
    endfunction

    function automatic t_q add_sat(input t_q a, input t_q b);
        logic signed [64:0] s;
        t_q                 r;
        s = 65'(a) + 65'(b);
        if (s > 65'(MAXV)) begin
            r = MAXV;
        end else if (s < -65'(MAXV)) begin
            r = -MAXV;
        end else begin
            r = t_q'(s);
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input t_q a);
        t_q r;
        r = a;
        if (r > OUT_MAX) begin
            r = OUT_MAX;
        end else if (r < OUT_MIN) begin
            r = OUT_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic t_q cmul(input logic signed [REG_W-1:0] c, input int k);
        return 64'(c) * 64'(k);
    endfunction

endpackage

// ===== design/qcon_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcon_div
// Pipelined restoring divider, one quotient bit per stage, saturating to MAXV.
// ----------------------------------------------------------------------------
module qcon_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qcon_pkg::t_tag     i_tag,
    input  logic [63:0]        i_hi,
    input  logic [63:0]        i_lo,
    input  logic [63:0]        i_den,
    output qcon_pkg::t_tag     o_tag,
    output logic [63:0]        o_quo
);
    import qcon_pkg::*;

    logic [63:0] r_rem [DIV_LAT];
    logic [63:0] r_lo  [DIV_LAT];
    logic [63:0] r_den [DIV_LAT];
    logic        r_sat [DIV_LAT];
    t_tag        r_tag [DIV_LAT];

    logic [63:0] w_rem [DIV_LAT];
    logic [63:0] w_lo  [DIV_LAT];
    logic [63:0] w_den [DIV_LAT];
    logic        w_sat [DIV_LAT];
    t_tag        w_tag [DIV_LAT];
    logic [63:0] n_rem [DIV_LAT];
    logic [63:0] n_lo  [DIV_LAT];

    always_comb begin
        w_rem[0] = i_hi;
        w_lo[0]  = i_lo;
        w_den[0] = i_den;
        w_sat[0] = (i_hi >= i_den);
        w_tag[0] = i_tag;
        for (int k = 1; k < DIV_LAT; k++) begin
            w_rem[k] = r_rem[k-1];
            w_lo[k]  = r_lo[k-1];
            w_den[k] = r_den[k-1];
            w_sat[k] = r_sat[k-1];
            w_tag[k] = r_tag[k-1];
        end
    end

    always_comb begin
        logic [63:0] rem1;
        logic        ge;
        for (int k = 0; k < DIV_LAT; k++) begin
            rem1     = {w_rem[k][62:0], w_lo[k][63]};
            ge       = w_rem[k][63] || (rem1 >= w_den[k]);
            n_rem[k] = ge ? (rem1 - w_den[k]) : rem1;
            n_lo[k]  = {w_lo[k][62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_LAT; k++) begin
            r_rem[k] <= n_rem[k];
            r_lo[k]  <= n_lo[k];
            r_den[k] <= w_den[k];
            r_sat[k] <= w_sat[k];
            r_tag[k] <= w_tag[k];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end
    end

    assign o_tag = r_tag[DIV_LAT-1];
    assign o_quo = (r_sat[DIV_LAT-1] || r_lo[DIV_LAT-1][63]) ? 64'(MAXV)
                                                              : r_lo[DIV_LAT-1];

endmodule

// ===== design/qcon_asphere_sag_and_slopes_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcon_asphere_sag_and_slopes_top
// Q-polynomial aspheric sag with first and second derivatives, fixed point.
// ----------------------------------------------------------------------------
// One surface point is taken every clock and its six words come out, each on
// o_sag..o_curv_yy for a single cycle flagged by o_valid; there is no
// back-pressure, so busy stays low and the receiver must take every word. The
// pipeline runs through the four 64-stage bit-per-stage dividers that form v,
// its x/y derivatives and 2/rn^2, followed by eight three-stage Horner steps
// and the chain-rule products. Registers may only be written while no point
// is in flight.
module qcon_asphere_sag_and_slopes_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [qcon_pkg::IDX_W-1:0]            i_cfg_idx,
    input  logic [qcon_pkg::REG_W-1:0]            i_cfg_data,
    input  logic signed [31:0]                    i_pos_x,
    input  logic signed [31:0]                    i_pos_y,
    output logic                                  o_valid,
    output logic signed [qcon_pkg::OUT_W-1:0]     o_sag,
    output logic signed [qcon_pkg::OUT_W-1:0]     o_slope_x,
    output logic signed [qcon_pkg::OUT_W-1:0]     o_slope_y,
    output logic signed [qcon_pkg::OUT_W-1:0]     o_curv_xx,
    output logic signed [qcon_pkg::OUT_W-1:0]     o_curv_xy,
    output logic signed [qcon_pkg::OUT_W-1:0]     o_curv_yy
);
    import qcon_pkg::*;

    localparam int CH_Z  = 0;
    localparam int CH_D  = 1;
    localparam int CH_DD = 2;
    localparam int P_TX  = 0;
    localparam int P_TY  = 1;
    localparam int P_SX  = 2;
    localparam int P_SY  = 3;
    localparam int P_DXX = 4;
    localparam int Q_XX  = 0;
    localparam int Q_XY  = 1;
    localparam int Q_YY  = 2;

    // registers
    logic [REG_W-1:0]        r_norm_radius;
    logic signed [REG_W-1:0] r_coef [7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_radius <= '0;
            for (int m = 0; m < 7; m++) begin
                r_coef[m] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_NORM_RADIUS: begin
                    r_norm_radius <= i_cfg_data;
                end
                default: begin
                    r_coef[IDX_W'(i_cfg_idx - IDX_W'(REG_COEF_0))] <= i_cfg_data;
                end
            endcase
        end
    end

    // polynomial coefficients for z, z' and z''
    t_q r_cp [NUM_TERMS][NUM_TERMS];
    t_q w_p  [NUM_TERMS];
    t_q r_p  [NUM_TERMS];
    t_q r_hcoef [N_CHAIN][N_COEF];
    t_q w_hcoef [N_CHAIN][N_COEF];

    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            w_p[i] = '0;
            for (int m = i; m < NUM_TERMS; m++) begin
                w_p[i] = w_p[i] + r_cp[m][i];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N_COEF; k++) begin
            for (int c = 0; c < N_CHAIN; c++) begin
                w_hcoef[c][k] = '0;
            end
        end
        for (int i = 0; i < NUM_TERMS; i++) begin
            w_hcoef[CH_Z][i+2] = r_p[i] <<< 8;
            w_hcoef[CH_D][i+1] = (r_p[i] <<< 8) * 64'(i + 2);
            w_hcoef[CH_DD][i]  = (r_p[i] <<< 8) * 64'((i + 2) * (i + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < NUM_TERMS; m++) begin
            for (int i = 0; i <= m; i++) begin
                r_cp[m][i] <= cmul(r_coef[m], Q_ROM[m][i]);
            end
        end
        for (int i = 0; i < NUM_TERMS; i++) begin
            r_p[i] <= w_p[i];
        end
        for (int k = 0; k < N_COEF; k++) begin
            for (int c = 0; c < N_CHAIN; c++) begin
                r_hcoef[c][k] <= w_hcoef[c][k];
            end
        end
    end

    // front end: magnitudes, squares, radius squared
    logic              r_s0_valid;
    logic signed [31:0] r_s0_x;
    logic signed [31:0] r_s0_y;
    logic [REG_W-1:0]  r_s0_rn;
    logic [31:0]       w_ax;
    logic [31:0]       w_ay;
    t_tag              r_s1_tag;
    logic [63:0]       r_s1_ax2;
    logic [63:0]       r_s1_ay2;
    logic [63:0]       r_s1_r2;
    logic [31:0]       r_s1_ax;
    logic [31:0]       r_s1_ay;
    t_tag              r_s2_tag;
    logic [63:0]       r_s2_s;
    logic [63:0]       r_s2_r2;
    logic [31:0]       r_s2_ax;
    logic [31:0]       r_s2_ay;

    assign busy = 1'b0;
    assign w_ax = r_s0_x[31] ? 32'(-r_s0_x) : 32'(r_s0_x);
    assign w_ay = r_s0_y[31] ? 32'(-r_s0_y) : 32'(r_s0_y);

    always_ff @(posedge i_clk) begin
        r_s0_x         <= i_pos_x;
        r_s0_y         <= i_pos_y;
        r_s0_rn        <= r_norm_radius;
        r_s1_ax2       <= {32'd0, w_ax} * {32'd0, w_ax};
        r_s1_ay2       <= {32'd0, w_ay} * {32'd0, w_ay};
        r_s1_r2        <= {32'd0, r_s0_rn} * {32'd0, r_s0_rn};
        r_s1_ax        <= w_ax;
        r_s1_ay        <= w_ay;
        r_s1_tag.zero  <= (r_s0_rn == '0);
        r_s1_tag.neg_x <= r_s0_x[31];
        r_s1_tag.neg_y <= r_s0_y[31];
        r_s2_s         <= r_s1_ax2 + r_s1_ay2;
        r_s2_r2        <= r_s1_r2;
        r_s2_ax        <= r_s1_ax;
        r_s2_ay        <= r_s1_ay;
        r_s2_tag       <= r_s1_tag;
        if (!i_rst_n) begin
            r_s0_valid     <= 1'b0;
            r_s1_tag.valid <= 1'b0;
            r_s2_tag.valid <= 1'b0;
        end else begin
            r_s0_valid     <= start && !busy;
            r_s1_tag.valid <= r_s0_valid;
        end
    end

    // dividers
    t_tag        w_tag_v;
    logic [63:0] w_q_v;
    logic [63:0] w_q_vx;
    logic [63:0] w_q_vy;
    logic [63:0] w_q_vxx;
    t_side       w_div_sd;

    qcon_div u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s2_tag),
        .i_hi    ({32'd0, r_s2_s[63:32]}),
        .i_lo    ({r_s2_s[31:0], 32'd0}),
        .i_den   (r_s2_r2),
        .o_tag   (w_tag_v),
        .o_quo   (w_q_v)
    );

    qcon_div u_div_vx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s2_tag),
        .i_hi    (64'(r_s2_ax >> 15)),
        .i_lo    ({r_s2_ax[14:0], 49'd0}),
        .i_den   (r_s2_r2),
        .o_tag   (),
        .o_quo   (w_q_vx)
    );

    qcon_div u_div_vy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s2_tag),
        .i_hi    (64'(r_s2_ay >> 15)),
        .i_lo    ({r_s2_ay[14:0], 49'd0}),
        .i_den   (r_s2_r2),
        .o_tag   (),
        .o_quo   (w_q_vy)
    );

    qcon_div u_div_vxx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s2_tag),
        .i_hi    (64'd2),
        .i_lo    (64'd0),
        .i_den   (r_s2_r2),
        .o_tag   (),
        .o_quo   (w_q_vxx)
    );

    always_comb begin
        w_div_sd.valid = w_tag_v.valid;
        w_div_sd.zero  = w_tag_v.zero;
        w_div_sd.v     = t_q'(w_q_v);
        w_div_sd.vx    = w_tag_v.neg_x ? -t_q'(w_q_vx) : t_q'(w_q_vx);
        w_div_sd.vy    = w_tag_v.neg_y ? -t_q'(w_q_vy) : t_q'(w_q_vy);
        w_div_sd.vxx   = t_q'(w_q_vxx);
    end

    // horner steps: product terms, rounding, accumulate
    t_q    w_acc_in [N_STEP][N_CHAIN];
    t_side w_sd_in  [N_STEP];
    t_pp   r_ha_pp  [N_STEP][N_CHAIN];
    t_side r_ha_sd  [N_STEP];
    t_q    r_hb_pr  [N_STEP][N_CHAIN];
    t_side r_hb_sd  [N_STEP];
    t_q    r_hc_acc [N_STEP][N_CHAIN];
    t_side r_hc_sd  [N_STEP];

    always_comb begin
        w_sd_in[0] = w_div_sd;
        for (int c = 0; c < N_CHAIN; c++) begin
            w_acc_in[0][c] = r_hcoef[c][N_COEF-1];
        end
        for (int s = 1; s < N_STEP; s++) begin
            w_sd_in[s] = r_hc_sd[s-1];
            for (int c = 0; c < N_CHAIN; c++) begin
                w_acc_in[s][c] = r_hc_acc[s-1][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < N_STEP; s++) begin
            for (int c = 0; c < N_CHAIN; c++) begin
                r_ha_pp[s][c]  <= mulq_pp(w_acc_in[s][c], w_sd_in[s].v);
                r_hb_pr[s][c]  <= mulq_fin(r_ha_pp[s][c]);
                r_hc_acc[s][c] <= add_sat(r_hb_pr[s][c], r_hcoef[c][N_COEF-2-s]);
            end
            r_ha_sd[s] <= w_sd_in[s];
            r_hb_sd[s] <= r_ha_sd[s];
            r_hc_sd[s] <= r_hb_sd[s];
        end
        if (!i_rst_n) begin
            for (int s = 0; s < N_STEP; s++) begin
                r_ha_sd[s].valid <= 1'b0;
                r_hb_sd[s].valid <= 1'b0;
                r_hc_sd[s].valid <= 1'b0;
            end
        end
    end

    // chain rule
    t_q    w_z;
    t_q    w_dz;
    t_q    w_ddz;
    t_side w_hsd;
    t_pp   r_t1_pp [5];
    t_side r_t1_sd;
    t_q    r_t1_z;
    t_q    r_t2_pr [5];
    t_side r_t2_sd;
    t_q    r_t2_z;
    t_pp   r_u1_pp [3];
    t_side r_u1_sd;
    t_q    r_u1_z;
    t_q    r_u1_sx;
    t_q    r_u1_sy;
    t_q    r_u1_dxx;
    t_q    r_u2_pr [3];
    t_side r_u2_sd;
    t_q    r_u2_z;
    t_q    r_u2_sx;
    t_q    r_u2_sy;
    t_q    r_u2_dxx;
    logic  r_w_valid;
    logic  r_w_zero;
    t_q    r_w_z;
    t_q    r_w_sx;
    t_q    r_w_sy;
    t_q    r_w_xx;
    t_q    r_w_xy;
    t_q    r_w_yy;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_sag;
    logic signed [OUT_W-1:0] r_out_slope_x;
    logic signed [OUT_W-1:0] r_out_slope_y;
    logic signed [OUT_W-1:0] r_out_curv_xx;
    logic signed [OUT_W-1:0] r_out_curv_xy;
    logic signed [OUT_W-1:0] r_out_curv_yy;

    assign w_z   = r_hc_acc[N_STEP-1][CH_Z];
    assign w_dz  = r_hc_acc[N_STEP-1][CH_D];
    assign w_ddz = r_hc_acc[N_STEP-1][CH_DD];
    assign w_hsd = r_hc_sd[N_STEP-1];

    always_ff @(posedge i_clk) begin
        r_t1_pp[P_TX]  <= mulq_pp(w_ddz, w_hsd.vx);
        r_t1_pp[P_TY]  <= mulq_pp(w_ddz, w_hsd.vy);
        r_t1_pp[P_SX]  <= mulq_pp(w_dz, w_hsd.vx);
        r_t1_pp[P_SY]  <= mulq_pp(w_dz, w_hsd.vy);
        r_t1_pp[P_DXX] <= mulq_pp(w_dz, w_hsd.vxx);
        r_t1_sd        <= w_hsd;
        r_t1_z         <= w_z;

        for (int k = 0; k < 5; k++) begin
            r_t2_pr[k] <= mulq_fin(r_t1_pp[k]);
        end
        r_t2_sd <= r_t1_sd;
        r_t2_z  <= r_t1_z;

        r_u1_pp[Q_XX] <= mulq_pp(r_t2_pr[P_TX], r_t2_sd.vx);
        r_u1_pp[Q_XY] <= mulq_pp(r_t2_pr[P_TX], r_t2_sd.vy);
        r_u1_pp[Q_YY] <= mulq_pp(r_t2_pr[P_TY], r_t2_sd.vy);
        r_u1_sd       <= r_t2_sd;
        r_u1_z        <= r_t2_z;
        r_u1_sx       <= r_t2_pr[P_SX];
        r_u1_sy       <= r_t2_pr[P_SY];
        r_u1_dxx      <= r_t2_pr[P_DXX];

        for (int k = 0; k < 3; k++) begin
            r_u2_pr[k] <= mulq_fin(r_u1_pp[k]);
        end
        r_u2_sd  <= r_u1_sd;
        r_u2_z   <= r_u1_z;
        r_u2_sx  <= r_u1_sx;
        r_u2_sy  <= r_u1_sy;
        r_u2_dxx <= r_u1_dxx;

        r_w_zero <= r_u2_sd.zero;
        r_w_z    <= r_u2_z;
        r_w_sx   <= r_u2_sx;
        r_w_sy   <= r_u2_sy;
        r_w_xx   <= add_sat(r_u2_pr[Q_XX], r_u2_dxx);
        r_w_xy   <= r_u2_pr[Q_XY];
        r_w_yy   <= add_sat(r_u2_pr[Q_YY], r_u2_dxx);

        r_out_sag     <= r_w_zero ? '0 : to_out(r_w_z);
        r_out_slope_x <= r_w_zero ? '0 : to_out(r_w_sx);
        r_out_slope_y <= r_w_zero ? '0 : to_out(r_w_sy);
        r_out_curv_xx <= r_w_zero ? '0 : to_out(r_w_xx);
        r_out_curv_xy <= r_w_zero ? '0 : to_out(r_w_xy);
        r_out_curv_yy <= r_w_zero ? '0 : to_out(r_w_yy);

        if (!i_rst_n) begin
            r_t1_sd.valid <= 1'b0;
            r_t2_sd.valid <= 1'b0;
            r_u1_sd.valid <= 1'b0;
            r_u2_sd.valid <= 1'b0;
            r_w_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_w_valid   <= r_u2_sd.valid;
            r_out_valid <= r_w_valid;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_sag     = r_out_sag;
    assign o_slope_x = r_out_slope_x;
    assign o_slope_y = r_out_slope_y;
    assign o_curv_xx = r_out_curv_xx;
    assign o_curv_xy = r_out_curv_xy;
    assign o_curv_yy = r_out_curv_yy;

    // every accepted point leaves after the fixed latency
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("accepted point did not produce a result word");

    // no result word without an accepted point
    a_word_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result word without accepted point");

    // divider tag lines stay in step with the pipeline valid
    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag_v.valid |=> r_ha_sd[0].valid)
        else $error("divider output lost before first horner step");

endmodule

// ===== sim/qcon_sag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcon_sag_checker
// Watches the point, register and result ports of the Q-polynomial sag unit,
// keeps its own copy of the registers, works out the six expected words for
// every accepted point and compares each result word, field by field, with
// the oldest expectation. Reports the number of failures and words in flight.
// ----------------------------------------------------------------------------
module qcon_sag_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_cfg_we,
    input  logic [qcon_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [qcon_pkg::REG_W-1:0]        i_cfg_data,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_y,
    input  logic                              i_valid,
    input  logic signed [qcon_pkg::OUT_W-1:0] i_sag,
    input  logic signed [qcon_pkg::OUT_W-1:0] i_slope_x,
    input  logic signed [qcon_pkg::OUT_W-1:0] i_slope_y,
    input  logic signed [qcon_pkg::OUT_W-1:0] i_curv_xx,
    input  logic signed [qcon_pkg::OUT_W-1:0] i_curv_xy,
    input  logic signed [qcon_pkg::OUT_W-1:0] i_curv_yy,
    output int                                o_fail_count,
    output int                                o_pending
);
    import qcon_pkg::*;

    typedef logic signed [63:0] fx_t;
    typedef logic signed [OUT_W-1:0] word_t;

    typedef struct {
        word_t f[6];
    } surf_word_t;

    localparam fx_t SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fx_t CLIP_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam fx_t CLIP_LO = -64'sh0000_8000_0000_0000;

    logic [31:0] radius;
    fx_t         weight[7];
    surf_word_t  surf_q[$];

    function automatic logic [63:0] magn(input fx_t a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic fx_t fx_mul(input fx_t a, input fx_t b);
        logic [127:0] prod;
        logic [127:0] q;
        fx_t          r;
        prod = {64'd0, magn(a)} * {64'd0, magn(b)};
        q    = (prod + 128'h8000_0000) >> 32;
        r    = (q > 128'(SAT_HI)) ? SAT_HI : fx_t'(q[63:0]);
        return (a[63] ^ b[63]) ? -r : r;
    endfunction

    function automatic fx_t fx_add(input fx_t a, input fx_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sd0 + SAT_HI) return SAT_HI;
        if (s < -(65'sd0 + SAT_HI)) return -SAT_HI;
        return fx_t'(s);
    endfunction

    function automatic logic [63:0] fx_div(input logic [127:0] num, input logic [63:0] d);
        logic [127:0] q;
        if (num[127:64] >= d) return 64'(SAT_HI);
        q = num / {64'd0, d};
        return (q > 128'(SAT_HI)) ? 64'(SAT_HI) : q[63:0];
    endfunction

    function automatic fx_t horner_eval(input fx_t c[9], input int n, input fx_t v);
        fx_t acc;
        acc = c[n-1];
        for (int k = n - 2; k >= 0; k--) begin
            acc = fx_add(fx_mul(acc, v), c[k]);
        end
        return acc;
    endfunction

    function automatic word_t clip(input fx_t a);
        fx_t r;
        r = a;
        if (r > CLIP_HI) r = CLIP_HI;
        if (r < CLIP_LO) r = CLIP_LO;
        return r[OUT_W-1:0];
    endfunction

    function automatic surf_word_t surface_at(input logic signed [31:0] px,
                                              input logic signed [31:0] py);
        surf_word_t  w;
        fx_t         xs, ys, v, vx, vy, vxx, z, dz, ddz, tx, ty, p;
        logic [63:0] ax, ay, r2, s;
        fx_t         zc[9], d1[9], d2[9];
        xs = px;
        ys = py;
        if (radius == 32'd0) begin
            for (int i = 0; i < 6; i++) w.f[i] = '0;
            return w;
        end
        ax  = magn(xs);
        ay  = magn(ys);
        r2  = {32'd0, radius} * {32'd0, radius};
        s   = ax * ax + ay * ay;
        v   = fx_t'(fx_div(128'(s) << 32, r2));
        vx  = fx_t'(fx_div(128'(ax) << 49, r2));
        vy  = fx_t'(fx_div(128'(ay) << 49, r2));
        vxx = fx_t'(fx_div(128'd1 << 65, r2));
        if (xs[63]) vx = -vx;
        if (ys[63]) vy = -vy;
        for (int i = 0; i < 9; i++) begin
            zc[i] = '0;
            d1[i] = '0;
            d2[i] = '0;
        end
        for (int i = 0; i < NUM_TERMS; i++) begin
            p = '0;
            for (int m = i; m < NUM_TERMS; m++) begin
                p = p + weight[m] * fx_t'(Q_ROM[m][i]);
            end
            zc[i+2] = p * 256;
        end
        for (int i = 0; i <= NUM_TERMS; i++) d1[i] = zc[i+1] * fx_t'(i + 1);
        for (int i = 0; i < NUM_TERMS; i++) d2[i] = zc[i+2] * fx_t'((i + 2) * (i + 1));
        z   = horner_eval(zc, NUM_TERMS + 2, v);
        dz  = horner_eval(d1, NUM_TERMS + 1, v);
        ddz = horner_eval(d2, NUM_TERMS, v);
        tx  = fx_mul(ddz, vx);
        ty  = fx_mul(ddz, vy);
        w.f[0] = clip(z);
        w.f[1] = clip(fx_mul(dz, vx));
        w.f[2] = clip(fx_mul(dz, vy));
        w.f[3] = clip(fx_add(fx_mul(tx, vx), fx_mul(dz, vxx)));
        w.f[4] = clip(fx_mul(tx, vy));
        w.f[5] = clip(fx_add(fx_mul(ty, vy), fx_mul(dz, vxx)));
        return w;
    endfunction

    assign o_pending = surf_q.size();

    always @(posedge i_clk) begin
        surf_word_t want;
        word_t      got[6];
        t_reg_idx   ri;
        int         errs;
        if (!i_rst_n) begin
            radius = '0;
            for (int k = 0; k < 7; k++) weight[k] = '0;
            surf_q.delete();
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_cfg_we) begin
                ri = t_reg_idx'(i_cfg_idx);
                if (ri == REG_NORM_RADIUS) radius = i_cfg_data;
                else weight[int'(ri) - 1] = fx_t'(signed'(i_cfg_data));
            end
            if (i_valid) begin
                got = '{i_sag, i_slope_x, i_slope_y, i_curv_xx, i_curv_xy, i_curv_yy};
                if (surf_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual sag %h", $time, i_sag);
                    errs = errs + 1;
                end else begin
                    want = surf_q.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (got[i] !== want.f[i]) begin
                            $display("%0t: field %0d mismatch, expected %h, actual %h",
                                     $time, i, want.f[i], got[i]);
                            errs = errs + 1;
                        end
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            if (i_start && !i_busy) surf_q.push_back(surface_at(i_pos_x, i_pos_y));
        end
    end
endmodule

// ===== sim/tb_qcon_asphere_sag_and_slopes_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qcon_asphere_sag_and_slopes_top
// Drives surface points and register settings into the sag unit: a directed
// run over zero, unit, tiny and widest radius with extreme points, then random
// phases with fresh register settings and random sender gaps. A checker beside
// the unit predicts and compares every word; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_qcon_asphere_sag_and_slopes_top;
    import qcon_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_idx;
    logic [REG_W-1:0]         i_cfg_data;
    logic signed [31:0]       i_pos_x;
    logic signed [31:0]       i_pos_y;
    logic                     o_valid;
    logic signed [OUT_W-1:0]  o_sag, o_slope_x, o_slope_y;
    logic signed [OUT_W-1:0]  o_curv_xx, o_curv_xy, o_curv_yy;
    int                       fail_count;
    int                       pending;
    int                       cycles = 0;
    logic [31:0]              radius_now;
    bit                       no_gaps;

    qcon_asphere_sag_and_slopes_top dut (.*);

    qcon_sag_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_pos_x, .i_pos_y, .i_valid(o_valid), .i_sag(o_sag),
        .i_slope_x(o_slope_x), .i_slope_y(o_slope_y), .i_curv_xx(o_curv_xx),
        .i_curv_xy(o_curv_xy), .i_curv_yy(o_curv_yy), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    // all registers, back to back, only while nothing is in flight
    task automatic load_regs(input logic [31:0] rn, input logic [31:0] w[7]);
        wait_drained();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(k);
            i_cfg_data <= (k == 0) ? rn : w[k-1];
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        radius_now  = rn;
    endtask

    task automatic send_point(input logic [31:0] px, input logic [31:0] py);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [31:0] coord();
        logic [31:0] lim;
        logic [31:0] m;
        if ($urandom_range(0, 3) == 0) return $urandom;
        lim = (radius_now > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : radius_now;
        m   = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(1, 8);
            2: return 32'hFFFF_FFFF;
            5: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    logic [31:0] w[7];
    logic [31:0] edge_pts[6];

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_pos_x    = '0;
        i_pos_y    = '0;
        radius_now = '0;
        no_gaps    = 1'b1;
        edge_pts   = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero radius after reset
        for (int i = 0; i < 4; i++) send_point(edge_pts[i], edge_pts[5 - i]);
        start <= 1'b0;

        // unit radius, mixed weights
        w = '{32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 32'h0, 32'h0010_0000,
              32'hFFF0_0000, 32'h0001_0000};
        load_regs(32'h0001_0000, w);
        for (int i = 0; i < 6; i++) send_point(edge_pts[i], edge_pts[(i + 2) % 6]);
        send_point(32'h0000_8000, 32'hFFFF_8000);
        start <= 1'b0;

        // tiny radius drives the quotients into saturation
        load_regs(32'd1, w);
        for (int i = 0; i < 6; i++) send_point(edge_pts[i], edge_pts[i]);
        start <= 1'b0;

        // widest radius, extreme weights
        w = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        load_regs(32'hFFFF_FFFF, w);
        for (int i = 0; i < 6; i++) send_point(edge_pts[i], edge_pts[5 - i]);
        start <= 1'b0;

        for (int ph = 0; ph < 10; ph++) begin
            for (int k = 0; k < 7; k++) w[k] = pick_weight();
            load_regs((ph == 0) ? 32'h0002_0000 : pick_radius(), w);
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 200; n++) begin
                if (n == 100 && ph == 3) begin
                    // hold off until the pipe has emptied
                    start <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                send_point(coord(), coord());
            end
            start <= 1'b0;
        end

        @(posedge i_clk);
        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/qcon_pkg.sv
design/qcon_div.sv
design/qcon_asphere_sag_and_slopes_top.sv
sim/qcon_sag_checker.sv
sim/tb_qcon_asphere_sag_and_slopes_top.sv
